### hdl/tscan_pkg.sv
package tscan_pkg;

    // Text position width; positions and lengths wrap at this width
    localparam int POS_BITS = 24;
    // Width of the offset and length fields of a result word
    localparam int OUT_BITS = 24;

    // Character codes
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;

    typedef logic [POS_BITS-1:0] pos_t;

    typedef enum logic [3:0] {
        KIND_PLUS     = 4'd0,
        KIND_PLUS_EQ  = 4'd1,
        KIND_MINUS    = 4'd2,
        KIND_MINUS_EQ = 4'd3,
        KIND_TYPE     = 4'd4,
        KIND_STRUCT   = 4'd5,
        KIND_IDENT    = 4'd6,
        KIND_END      = 4'd7,
        KIND_ERROR    = 4'd8
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] length;
        logic                last;
    } result_t;

    // Results produced by one accepted word; the second slot is only used
    // together with the first
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    // Fit a position into an output field (truncate or zero-extend)
    function automatic logic [OUT_BITS-1:0] to_out(pos_t p);
        logic [POS_BITS+OUT_BITS-1:0] wide;
        wide = {{OUT_BITS{1'b0}}, p};
        return wide[OUT_BITS-1:0];
    endfunction

    function automatic result_t mk_result(kind_t k, pos_t s, pos_t l, logic last);
        result_t r;
        r.kind   = k;
        r.start  = to_out(s);
        r.length = to_out(l);
        r.last   = last;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NEWLINE);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_ident_first(logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
               (b == CH_UNDERSCORE) || (b == CH_DOLLAR);
    endfunction

    function automatic logic is_ident_more(logic [7:0] b);
        return is_ident_first(b) || is_digit(b);
    endfunction

    // Letters of the keyword "type"
    function automatic logic [7:0] kw_type_char(logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = 8'h74;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h70;
            3'd3:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Letters of the keyword "struct"
    function automatic logic [7:0] kw_struct_char(logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = 8'h73;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h72;
            3'd3:    c = 8'h75;
            3'd4:    c = 8'h63;
            3'd5:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### hdl/tscan_core.sv
module tscan_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_take,
    input  logic [7:0]         in_char,
    input  logic               in_end,
    output tscan_pkg::push_t   push
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PLUS,
        MODE_MINUS,
        MODE_IDENT
    } mode_t;

    mode_t                 mode_reg, mode_next;
    tscan_pkg::pos_t       pos_reg, pos_next;
    tscan_pkg::pos_t       tok_start_reg, tok_start_next;
    tscan_pkg::pos_t       err_start_reg, err_start_next;
    tscan_pkg::pos_t       err_end_reg, err_end_next;
    logic                  err_pend_reg, err_pend_next;
    logic [2:0]            id_len_reg, id_len_next;
    logic [1:0]            kw_match_reg, kw_match_next;
    tscan_pkg::push_t      push_comb;

    // Scan one word: flush the token it ends, then scan the byte afresh if needed
    always_comb begin
        tscan_pkg::pos_t   pos_inc;
        tscan_pkg::pos_t   tok_len;
        tscan_pkg::kind_t  id_kind;
        tscan_pkg::result_t end_res;
        logic              do_idle;

        pos_inc = pos_reg + tscan_pkg::pos_t'(1);
        tok_len = pos_reg - tok_start_reg;
        do_idle = 1'b0;

        if (kw_match_reg[0] && (id_len_reg == 3'd4)) begin
            id_kind = tscan_pkg::KIND_TYPE;
        end else if (kw_match_reg[1] && (id_len_reg == 3'd6)) begin
            id_kind = tscan_pkg::KIND_STRUCT;
        end else begin
            id_kind = tscan_pkg::KIND_IDENT;
        end

        mode_next      = mode_reg;
        pos_next       = pos_reg;
        tok_start_next = tok_start_reg;
        err_start_next = err_start_reg;
        err_end_next   = err_end_reg;
        err_pend_next  = err_pend_reg;
        id_len_next    = id_len_reg;
        kw_match_next  = kw_match_reg;
        push_comb      = '0;
        end_res        = tscan_pkg::mk_result(tscan_pkg::KIND_END, pos_reg, '0, 1'b1);

        if (in_end) begin
            // Flush the pending token or error span, then the end token
            push_comb.v0 = 1'b1;
            unique case (mode_reg)
                MODE_PLUS: begin
                    push_comb.r0 = tscan_pkg::mk_result(tscan_pkg::KIND_PLUS,
                                                        tok_start_reg, tok_len, 1'b0);
                end
                MODE_MINUS: begin
                    push_comb.r0 = tscan_pkg::mk_result(tscan_pkg::KIND_MINUS,
                                                        tok_start_reg, tok_len, 1'b0);
                end
                MODE_IDENT: begin
                    push_comb.r0 = tscan_pkg::mk_result(id_kind, tok_start_reg, tok_len,
                                                        1'b0);
                end
                MODE_IDLE: begin
                    if (err_pend_reg) begin
                        push_comb.r0 = tscan_pkg::mk_result(tscan_pkg::KIND_ERROR,
                            err_start_reg, err_end_reg - err_start_reg, 1'b0);
                    end else begin
                        push_comb.v0 = 1'b0;
                    end
                end
                default: push_comb.v0 = 1'b0;
            endcase
            if (push_comb.v0) begin
                push_comb.v1 = 1'b1;
                push_comb.r1 = end_res;
            end else begin
                push_comb.v0 = 1'b1;
                push_comb.r0 = end_res;
            end

            // Return to the reset state
            mode_next      = MODE_IDLE;
            pos_next       = '0;
            tok_start_next = '0;
            err_start_next = '0;
            err_end_next   = '0;
            err_pend_next  = 1'b0;
            id_len_next    = '0;
            kw_match_next  = 2'b11;
        end else begin
            unique case (mode_reg)
                MODE_PLUS, MODE_MINUS: begin
                    push_comb.v0 = 1'b1;
                    if (in_char == tscan_pkg::CH_EQUAL) begin
                        push_comb.r0 = tscan_pkg::mk_result(
                            (mode_reg == MODE_PLUS) ? tscan_pkg::KIND_PLUS_EQ
                                                    : tscan_pkg::KIND_MINUS_EQ,
                            tok_start_reg, pos_inc - tok_start_reg, 1'b1);
                        mode_next = MODE_IDLE;
                        pos_next  = pos_inc;
                    end else begin
                        // Lookahead miss: keep the byte for a fresh scan
                        push_comb.r0 = tscan_pkg::mk_result(
                            (mode_reg == MODE_PLUS) ? tscan_pkg::KIND_PLUS
                                                    : tscan_pkg::KIND_MINUS,
                            tok_start_reg, tok_len, 1'b1);
                        do_idle = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (tscan_pkg::is_ident_more(in_char)) begin
                        // Advance the keyword matcher
                        if ((id_len_reg >= 3'd4) ||
                            (tscan_pkg::kw_type_char(id_len_reg) != in_char)) begin
                            kw_match_next[0] = 1'b0;
                        end
                        if ((id_len_reg >= 3'd6) ||
                            (tscan_pkg::kw_struct_char(id_len_reg) != in_char)) begin
                            kw_match_next[1] = 1'b0;
                        end
                        if (id_len_reg != 3'd7) begin
                            id_len_next = id_len_reg + 3'd1;
                        end
                        pos_next = pos_inc;
                    end else begin
                        push_comb.v0 = 1'b1;
                        push_comb.r0 = tscan_pkg::mk_result(id_kind, tok_start_reg, tok_len,
                                                            1'b1);
                        do_idle = 1'b1;
                    end
                end
                MODE_IDLE: do_idle = 1'b1;
                default:   do_idle = 1'b1;
            endcase

            // Scan the byte between tokens
            if (do_idle) begin
                mode_next = MODE_IDLE;
                pos_next  = pos_inc;
                if (tscan_pkg::is_space(in_char)) begin
                    mode_next = MODE_IDLE;
                end else if ((in_char == tscan_pkg::CH_PLUS) ||
                             (in_char == tscan_pkg::CH_MINUS) ||
                             tscan_pkg::is_ident_first(in_char)) begin
                    if (err_pend_reg) begin
                        push_comb.v0 = 1'b1;
                        push_comb.r0 = tscan_pkg::mk_result(tscan_pkg::KIND_ERROR,
                            err_start_reg, err_end_reg - err_start_reg, 1'b1);
                        err_pend_next = 1'b0;
                    end
                    tok_start_next = pos_reg;
                    if (in_char == tscan_pkg::CH_PLUS) begin
                        mode_next = MODE_PLUS;
                    end else if (in_char == tscan_pkg::CH_MINUS) begin
                        mode_next = MODE_MINUS;
                    end else begin
                        mode_next        = MODE_IDENT;
                        id_len_next      = 3'd1;
                        kw_match_next[0] = (in_char == tscan_pkg::kw_type_char(3'd0));
                        kw_match_next[1] = (in_char == tscan_pkg::kw_struct_char(3'd0));
                    end
                end else begin
                    // Grow the error span
                    if (!err_pend_reg) begin
                        err_start_next = pos_reg;
                    end
                    err_pend_next = 1'b1;
                    err_end_next  = pos_inc;
                end
            end
        end

        if (!in_take) begin
            push_comb.v0 = 1'b0;
            push_comb.v1 = 1'b0;
        end
    end

    assign push = push_comb;

    // Hold the scan state; advance it on every accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            pos_reg       <= '0;
            tok_start_reg <= '0;
            err_start_reg <= '0;
            err_end_reg   <= '0;
            err_pend_reg  <= 1'b0;
            id_len_reg    <= '0;
            kw_match_reg  <= 2'b11;
        end else if (in_take) begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            tok_start_reg <= tok_start_next;
            err_start_reg <= err_start_next;
            err_end_reg   <= err_end_next;
            err_pend_reg  <= err_pend_next;
            id_len_reg    <= id_len_next;
            kw_match_reg  <= kw_match_next;
        end
    end

endmodule

### hdl/tscan_fifo.sv
module tscan_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  tscan_pkg::push_t    push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output tscan_pkg::result_t  out_head
);

    localparam int DEPTH   = 4;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    tscan_pkg::result_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PTR_W-1:0]    wr_ptr_inc;
    logic [1:0]          n_push;
    logic                pop;

    // Accept a word only when both result slots fit
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_head  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign n_push      = {1'b0, push.v0} + {1'b0, push.v1};
    assign wr_ptr_inc  = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);

    // Store result words
    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            mem_reg[wr_ptr_inc] <= push.r1;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/token_scanner_top.sv
// Token scanner: splits a byte stream of source text into tokens.
//
// Input channel (s_*): one source byte per word in s_tdata; s_tlast marks the
// end of the text and carries no byte. Output channel (m_*): one token per
// word (kind, start offset, length); m_tlast marks the final result word
// caused by an input word.
//
// A token is reported when the byte after it arrives (+= and -= when their
// '=' arrives); its result is registered in the output queue. The end-of-text
// word gives the pending token or error span (if any) and then the end token.
//
// Throughput: one input word per cycle while s_tready is high. Each word
// yields at most one result, except the end-of-text word, which may yield
// two. Results wait in a four-word output queue; s_tready drops while fewer
// than two slots are free, so a stalled receiver stops input at three queued.
//
// Reset (aresetn low, synchronous) clears the scan state and empties the
// queue. After the end-of-text word the scanner is back in its reset state.
module token_scanner_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_input

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [3:0] token_kind, [27:4] start_offset,
                                   // [51:28] span_length, [55:52] zero
    output logic        m_tlast    // last_of_item
);

    tscan_pkg::push_t    push;
    tscan_pkg::result_t  head;
    logic                in_take;

    assign in_take = s_tvalid && s_tready;

    tscan_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (in_take),
        .in_char (s_tdata),
        .in_end  (s_tlast),
        .push    (push)
    );

    tscan_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_head  (head)
    );

    assign m_tdata = {4'b0000, head.length, head.start, head.kind};
    assign m_tlast = head.last;

    // Results appear only for accepted words
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.v0 |-> in_take)
        else $error("result produced without an accepted word");

    // Two results come only from the end-of-text word
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.v1 |-> (push.v0 && in_take && s_tlast))
        else $error("second result outside end of text");

    // The end-of-text word closes with the end token
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_take && s_tlast) |->
            (push.v1 ? (push.r1.kind == tscan_pkg::KIND_END)
                     : (push.v0 && (push.r0.kind == tscan_pkg::KIND_END))))
        else $error("end of text without end token");

    // A single result is the last one of its word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.v0 && !push.v1) |-> push.r0.last)
        else $error("single result not marked last");

endmodule
